@@ hdl/sfq_pkg.sv @@
`timescale 1ns / 1ps

package sfq_pkg;

    // One quotient bit is resolved in each divider stage.
    localparam int DIV_STAGES = 26;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
    localparam logic [30:0] F32_INF     = 31'h7F80_0000;
    localparam logic [30:0] F32_QNAN    = 31'h7FC0_0000;
    localparam logic [30:0] F32_448     = 31'h43E0_0000;
    localparam logic [6:0]  E4M3_MAX    = 7'h7E;
    localparam logic [6:0]  E4M3_NAN    = 7'h7F;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] fp8_code;
        logic       last_out;
    } t_out_item;

    // Operand class of the quotient, settled before the divider.
    typedef enum logic [1:0] {
        CLS_NUM  = 2'd0,
        CLS_NAN  = 2'd1,
        CLS_INF  = 2'd2,
        CLS_ZERO = 2'd3
    } t_cls;

    typedef struct packed {
        logic sign;
        t_cls cls;
        logic last;
    } t_meta;

    // Leading zero count of a 24-bit word; 24 when the word is zero.
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    // Right shift with round-to-nearest-even; sticky flags nonzero bits below v.
    function automatic logic [25:0] rne_shift(input logic [25:0] v, input logic [4:0] sh,
                                              input logic sticky);
        logic [25:0] keep;
        logic [27:0] rem;
        logic [27:0] half;
        logic        up;
        logic [25:0] res;
        keep = v >> sh;
        rem  = {2'b00, v} & ((28'd1 << sh) - 28'd1);
        half = 28'd1 << (sh - 5'd1);
        up   = (rem > half) || ((rem == half) && (sticky || keep[0]));
        if (sh == 5'd0) begin
            res = v;
        end else begin
            res = keep + {25'd0, up};
        end
        return res;
    endfunction

endpackage

@@ hdl/scaled_fp8_e4m3_quantizer.sv @@
`timescale 1ns / 1ps

// Static per-tensor FP8 E4M3FN quantizer. Each input transaction carries one IEEE
// single-precision element, which is divided by the scale register (IEEE single,
// round-to-nearest-even, subnormals supported), clamped to +-448 and rounded to an
// E4M3FN code with round-to-nearest-even. A NaN quotient gives +448 (0x7E), infinite
// quotients saturate with their sign, zero keeps its sign. The block accepts one
// transaction per clock while the pipeline is not held and delivers one result per
// transaction, in order. Each transaction passes in turn through capture,
// classification, normalization, the divider, a 26-stage array that resolves one
// quotient bit per stage, and the two rounding stages. The whole pipeline
// advances together; it holds while the output register is full and stalled, and
// the input stall follows that condition. The scale register is written through the
// configuration channel, which is always ready, and must only be written while no
// transaction is in flight. Its reset value is 1.0.
module scaled_fp8_e4m3_quantizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sfq_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sfq_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    localparam int L = sfq_pkg::DIV_STAGES - 1;

    logic               cfg_write;
    logic [31:0]        r_scale_bits;
    logic               en;

    // Stage 1: capture.
    logic               r1_valid;
    logic [31:0]        r1_a;
    logic [31:0]        r1_b;
    logic               r1_last;

    // Stage 2: classification and leading zero counts.
    logic               r2_valid;
    sfq_pkg::t_meta     r2_meta;
    sfq_pkg::t_meta     n2_meta;
    logic [7:0]         r2_efa;
    logic [7:0]         r2_efb;
    logic [22:0]        r2_fa;
    logic [22:0]        r2_fb;
    logic [4:0]         r2_lza;
    logic [4:0]         r2_lzb;

    // Stage 3: normalized significands and quotient exponent.
    logic               r3_valid;
    sfq_pkg::t_meta     r3_meta;
    logic [24:0]        r3_ma;
    logic [23:0]        r3_mb;
    logic signed [9:0]  r3_e;
    logic [24:0]        n3_ma;
    logic [23:0]        n3_ma24;
    logic [23:0]        n3_mb;
    logic signed [9:0]  n3_ea;
    logic signed [9:0]  n3_eb;
    logic signed [9:0]  n3_e;

    // Divider array.
    logic [L:0]         r_dv_valid;
    logic [23:0]        r_dv_rem  [sfq_pkg::DIV_STAGES];
    logic [25:0]        r_dv_q    [sfq_pkg::DIV_STAGES];
    logic [23:0]        r_dv_mb   [sfq_pkg::DIV_STAGES];
    logic signed [9:0]  r_dv_e    [sfq_pkg::DIV_STAGES];
    sfq_pkg::t_meta     r_dv_meta [sfq_pkg::DIV_STAGES];
    logic [23:0]        n_dv_rem  [sfq_pkg::DIV_STAGES];
    logic [25:0]        n_dv_q    [sfq_pkg::DIV_STAGES];
    logic [24:0]        d_src     [sfq_pkg::DIV_STAGES];
    logic [23:0]        d_mb      [sfq_pkg::DIV_STAGES];
    logic [25:0]        d_q       [sfq_pkg::DIV_STAGES];
    logic [L:0]         d_bit;

    // Stage 4: single-precision rounding.
    logic               r4_valid;
    logic [30:0]        r4_mag;
    logic               r4_sign;
    logic               r4_last;
    logic [30:0]        n4_mag;
    logic signed [9:0]  n4_be;
    logic [4:0]         n4_sh;
    logic               n4_sticky;

    // Output register with the E4M3 conversion in front of it.
    logic               r_out_valid;
    sfq_pkg::t_out_item r_out;
    logic [6:0]         n_code;
    logic [7:0]         n_ef;
    logic signed [8:0]  n_e8;
    logic [4:0]         n_sh8;
    logic [25:0]        n_rnd8;

    assign cfg_write = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;

    // The pipeline moves unless a finished result is held by the receiver.
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_bits <= sfq_pkg::SCALE_RESET;
        end else if (cfg_write) begin
            r_scale_bits <= i_cfg_data;
        end
    end

    // Stage 2 logic: IEEE special cases are decided here and ride along as a class.
    always_comb begin
        n2_meta.sign = r1_a[31] ^ r1_b[31];
        n2_meta.last = r1_last;
        if ((r1_a[30:0] > sfq_pkg::F32_INF) || (r1_b[30:0] > sfq_pkg::F32_INF)
            || ((r1_a[30:0] == sfq_pkg::F32_INF) && (r1_b[30:0] == sfq_pkg::F32_INF))
            || ((r1_a[30:0] == 31'd0) && (r1_b[30:0] == 31'd0))) begin
            n2_meta.cls = sfq_pkg::CLS_NAN;
        end else if ((r1_a[30:0] == sfq_pkg::F32_INF) || (r1_b[30:0] == 31'd0)) begin
            n2_meta.cls = sfq_pkg::CLS_INF;
        end else if ((r1_a[30:0] == 31'd0) || (r1_b[30:0] == sfq_pkg::F32_INF)) begin
            n2_meta.cls = sfq_pkg::CLS_ZERO;
        end else begin
            n2_meta.cls = sfq_pkg::CLS_NUM;
        end
    end

    // Stage 3 logic: subnormal operands are normalized, and the dividend is doubled
    // when it is below the divisor so that the quotient always has its top bit set.
    always_comb begin
        if (r2_efa == 8'd0) begin
            n3_ma24 = {1'b0, r2_fa} << r2_lza;
            n3_ea   = -10'sd126 - $signed({5'd0, r2_lza});
        end else begin
            n3_ma24 = {1'b1, r2_fa};
            n3_ea   = $signed({2'b00, r2_efa}) - 10'sd127;
        end
        if (r2_efb == 8'd0) begin
            n3_mb = {1'b0, r2_fb} << r2_lzb;
            n3_eb = -10'sd126 - $signed({5'd0, r2_lzb});
        end else begin
            n3_mb = {1'b1, r2_fb};
            n3_eb = $signed({2'b00, r2_efb}) - 10'sd127;
        end
        if (n3_ma24 < n3_mb) begin
            n3_ma = {n3_ma24, 1'b0};
            n3_e  = n3_ea - n3_eb - 10'sd1;
        end else begin
            n3_ma = {1'b0, n3_ma24};
            n3_e  = n3_ea - n3_eb;
        end
    end

    // Restoring division: each stage compares the partial remainder with the
    // divisor and shifts one quotient bit in.
    always_comb begin
        d_src[0] = r3_ma;
        d_mb[0]  = r3_mb;
        d_q[0]   = 26'd0;
        for (int k = 1; k < sfq_pkg::DIV_STAGES; k++) begin
            d_src[k] = {r_dv_rem[k-1], 1'b0};
            d_mb[k]  = r_dv_mb[k-1];
            d_q[k]   = r_dv_q[k-1];
        end
        for (int k = 0; k < sfq_pkg::DIV_STAGES; k++) begin
            d_bit[k] = d_src[k] >= {1'b0, d_mb[k]};
            if (d_bit[k]) begin
                n_dv_rem[k] = 24'(d_src[k] - {1'b0, d_mb[k]});
            end else begin
                n_dv_rem[k] = d_src[k][23:0];
            end
            n_dv_q[k] = {d_q[k][24:0], d_bit[k]};
        end
    end

    // Stage 4 logic: round the 26-bit quotient to single precision, including the
    // gradual underflow range, and apply the special classes.
    always_comb begin
        n4_be     = r_dv_e[L] + 10'sd127;
        n4_sticky = r_dv_rem[L] != 24'd0;
        if (n4_be < -10'sd24) begin
            n4_sh = 5'd27;
        end else begin
            n4_sh = 5'(10'sd3 - n4_be);
        end
        unique case (r_dv_meta[L].cls)
            sfq_pkg::CLS_NAN:  n4_mag = sfq_pkg::F32_QNAN;
            sfq_pkg::CLS_INF:  n4_mag = sfq_pkg::F32_INF;
            sfq_pkg::CLS_ZERO: n4_mag = 31'd0;
            default: begin
                if (n4_be >= 10'sd255) begin
                    n4_mag = sfq_pkg::F32_INF;
                end else if (n4_be >= 10'sd1) begin
                    n4_mag = {n4_be[7:0] - 8'd1, 23'd0}
                        + {5'd0, sfq_pkg::rne_shift(r_dv_q[L], 5'd2, n4_sticky)};
                end else begin
                    n4_mag = {5'd0, sfq_pkg::rne_shift(r_dv_q[L], n4_sh, n4_sticky)};
                end
            end
        endcase
    end

    // Output logic: clamp to the E4M3FN range and round to three mantissa bits.
    always_comb begin
        n_ef = r4_mag[30:23];
        n_e8 = $signed({1'b0, n_ef}) - 9'sd120;
        if (n_e8 < -9'sd4) begin
            n_sh8 = 5'd25;
        end else begin
            n_sh8 = 5'(9'sd21 - n_e8);
        end
        if (n_e8 >= 9'sd1) begin
            n_rnd8 = sfq_pkg::rne_shift({2'b00, 1'b1, r4_mag[22:0]}, 5'd20, 1'b0);
        end else begin
            n_rnd8 = sfq_pkg::rne_shift({2'b00, 1'b1, r4_mag[22:0]}, n_sh8, 1'b0);
        end
        priority if (r4_mag > sfq_pkg::F32_INF) begin
            n_code = sfq_pkg::E4M3_MAX;
        end else if (r4_mag >= sfq_pkg::F32_448) begin
            n_code = sfq_pkg::E4M3_MAX;
        end else if (n_ef == 8'd0) begin
            n_code = 7'd0;
        end else if (n_e8 >= 9'sd1) begin
            n_code = {n_e8[3:0] - 4'd1, 3'b000} + n_rnd8[6:0];
        end else begin
            n_code = n_rnd8[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_dv_valid  <= '0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_dv_valid  <= {r_dv_valid[L-1:0], r3_valid};
            r4_valid    <= r_dv_valid[L];
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= i_in.value_bits;
            r1_b    <= r_scale_bits;
            r1_last <= i_in.last_in;

            r2_meta <= n2_meta;
            r2_efa  <= r1_a[30:23];
            r2_efb  <= r1_b[30:23];
            r2_fa   <= r1_a[22:0];
            r2_fb   <= r1_b[22:0];
            r2_lza  <= sfq_pkg::lzc24({1'b0, r1_a[22:0]});
            r2_lzb  <= sfq_pkg::lzc24({1'b0, r1_b[22:0]});

            r3_meta <= r2_meta;
            r3_ma   <= n3_ma;
            r3_mb   <= n3_mb;
            r3_e    <= n3_e;

            for (int k = 0; k < sfq_pkg::DIV_STAGES; k++) begin
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_q[k]   <= n_dv_q[k];
                r_dv_mb[k]  <= d_mb[k];
            end
            r_dv_e[0]    <= r3_e;
            r_dv_meta[0] <= r3_meta;
            for (int k = 1; k < sfq_pkg::DIV_STAGES; k++) begin
                r_dv_e[k]    <= r_dv_e[k-1];
                r_dv_meta[k] <= r_dv_meta[k-1];
            end

            r4_mag  <= n4_mag;
            r4_sign <= r_dv_meta[L].sign;
            r4_last <= r_dv_meta[L].last;

            r_out.fp8_code <= {(r4_mag > sfq_pkg::F32_INF) ? 1'b0 : r4_sign, n_code};
            r_out.last_out <= r4_last;
        end
    end

    // A finite nonzero quotient always leaves the divider with its leading bit set.
    a_quot_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[L] && (r_dv_meta[L].cls == sfq_pkg::CLS_NUM)) |-> r_dv_q[L][25])
        else $error("divider quotient not normalized");

    // The final partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[L] && (r_dv_meta[L].cls == sfq_pkg::CLS_NUM))
            |-> (r_dv_rem[L] < r_dv_mb[L]))
        else $error("divider remainder out of range");

    // The NaN encoding is never produced.
    a_no_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.fp8_code[6:0] != sfq_pkg::E4M3_NAN))
        else $error("E4M3 NaN code produced");

    // A held pipeline keeps its in-flight quotients.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_dv_valid[L]) |=> ($stable(r_dv_q[L]) && $stable(r4_mag)))
        else $error("pipeline moved while stalled");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_DRAIN  = 40;    // a little more than the pipeline latency
    localparam int STALL_LIMIT = 3000;  // cycles without any transaction
    localparam int RAND_PER_SCALE = 130;
    localparam int LONG_HOLD   = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    sfq_pkg::t_in_item i_in;
    logic              o_out_valid;
    logic              i_out_stall;
    sfq_pkg::t_out_item o_out;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [31:0]       i_cfg_data;

    scaled_fp8_e4m3_quantizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Elements still to be sent and FP8 codes still to be received.
    sfq_pkg::t_in_item  element_q[$];
    sfq_pkg::t_out_item fp8_expect_q[$];

    logic [31:0] scale_shadow;  // what the scale register holds
    int          phase_num;
    bit          quiet;          // no idling on either side
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          idle_cycles;

    always #1 i_clk = ~i_clk;

    // Right shift with round-to-nearest-even; sticky marks dropped bits beyond v.
    function automatic logic [63:0] shift_round(logic [63:0] v, int sh, bit sticky);
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh == 0) begin
            return v;
        end
        if (sh > 62) begin
            sh = 62;
        end
        keep = v >> sh;
        rem  = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && (sticky || keep[0]))) begin
            keep++;
        end
        return keep;
    endfunction

    // Finite nonzero magnitude to a significand with bit 23 set and an unbiased exponent.
    function automatic void split_single(logic [30:0] mag, output logic [63:0] sig,
                                         output int expo);
        logic [7:0] ef;
        ef  = mag[30:23];
        sig = {41'd0, mag[22:0]};
        if (ef == 8'd0) begin
            expo = -126;
            while (sig < 64'h80_0000) begin
                sig  = sig << 1;
                expo = expo - 1;
            end
        end else begin
            sig  = sig | 64'h80_0000;
            expo = int'(ef) - 127;
        end
    endfunction

    // IEEE single a / b with round-to-nearest-even.
    function automatic logic [31:0] divide_single(logic [31:0] a, logic [31:0] b);
        logic        sgn;
        logic [30:0] ma_bits;
        logic [30:0] mb_bits;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] bits;
        int          ea;
        int          eb;
        int          e;
        int          be;
        bit          sticky;
        sgn     = a[31] ^ b[31];
        ma_bits = a[30:0];
        mb_bits = b[30:0];
        if (ma_bits > sfq_pkg::F32_INF || mb_bits > sfq_pkg::F32_INF) begin
            return {1'b0, sfq_pkg::F32_QNAN};
        end
        if ((ma_bits == sfq_pkg::F32_INF && mb_bits == sfq_pkg::F32_INF)
                || (ma_bits == 0 && mb_bits == 0)) begin
            return {1'b0, sfq_pkg::F32_QNAN};
        end
        if (ma_bits == sfq_pkg::F32_INF || mb_bits == 0) begin
            return {sgn, sfq_pkg::F32_INF};
        end
        if (ma_bits == 0 || mb_bits == sfq_pkg::F32_INF) begin
            return {sgn, 31'd0};
        end
        split_single(ma_bits, ma, ea);
        split_single(mb_bits, mb, eb);
        e = ea - eb;
        if (ma < mb) begin
            ma = ma << 1;
            e  = e - 1;
        end
        q      = (ma << 25) / mb;
        sticky = ((ma << 25) % mb) != 0;
        be     = e + 127;
        if (be >= 255) begin
            return {sgn, sfq_pkg::F32_INF};
        end
        if (be >= 1) begin
            bits = (64'(be - 1) << 23) + shift_round(q, 2, sticky);
        end else begin
            bits = shift_round(q, 3 - be, sticky);
        end
        return {sgn, bits[30:0]};
    endfunction

    // Clamp to +-448 (NaN drops out to +448) and round to an E4M3FN code.
    function automatic logic [7:0] single_to_e4m3(logic [31:0] f);
        logic [30:0] mag;
        logic [63:0] sig;
        logic [63:0] code;
        int          e8;
        mag = f[30:0];
        if (mag > sfq_pkg::F32_INF) begin
            return {1'b0, sfq_pkg::E4M3_MAX};
        end
        if (mag >= sfq_pkg::F32_448) begin
            return {f[31], sfq_pkg::E4M3_MAX};
        end
        if (mag[30:23] == 8'd0) begin
            return {f[31], 7'd0};
        end
        sig = {41'd1, mag[22:0]};
        sig = sig & 64'hFF_FFFF;
        sig = sig | 64'h80_0000;
        e8  = int'(mag[30:23]) - 127 + 7;
        if (e8 >= 1) begin
            code = (64'(e8 - 1) << 3) + shift_round(sig, 20, 1'b0);
        end else begin
            code = shift_round(sig, 21 - e8, 1'b0);
        end
        return {f[31], code[6:0]};
    endfunction

    function automatic sfq_pkg::t_out_item quantize_element(sfq_pkg::t_in_item item,
                                                            logic [31:0] scale);
        sfq_pkg::t_out_item r;
        r.fp8_code = single_to_e4m3(divide_single(item.value_bits, scale));
        r.last_out = item.last_in;
        return r;
    endfunction

    // Random element: mostly near the scale so the quotient lands in the FP8 range,
    // plus raw patterns and the IEEE special values.
    function automatic logic [31:0] random_element(logic [31:0] scale);
        int pick;
        int ex;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        if (pick < 60) begin
            ex = int'(scale[30:23]) + $urandom_range(0, 26) - 16;
            if (scale[30:23] == 8'd0 || scale[30:23] == 8'hFF) begin
                ex = $urandom_range(0, 254);
            end
            if (ex < 0) begin
                ex = 0;
            end
            if (ex > 254) begin
                ex = 254;
            end
            v[30:23] = ex[7:0];
        end else if (pick < 85) begin
            v[30:23] = v[30:23];
        end else begin
            case ($urandom_range(0, 4))
                0: v[30:0] = 31'd0;
                1: v[30:0] = sfq_pkg::F32_INF;
                2: v[30:23] = 8'hFF;
                3: v[30:23] = 8'd0;
                default: v[30:0] = sfq_pkg::F32_448;
            endcase
            if (v[30:0] == {8'hFF, 23'd0} && pick[0]) begin
                v[0] = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic queue_element(logic [31:0] v, logic last);
        sfq_pkg::t_in_item item;
        item.value_bits = v;
        item.last_in    = last;
        element_q.push_back(item);
    endtask

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) begin
            queue_element(random_element(scale_shadow), ($urandom_range(0, 15) == 0));
        end
    endtask

    // Waits until every element has gone through and the pipeline has emptied.
    task automatic wait_drained();
        while (element_q.size() != 0 || fp8_expect_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid  <= 1'b0;
        scale_shadow = v;
    endtask

    // Sender: holds each transaction until accepted, with random gaps in between.
    int send_gap;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                fp8_expect_q.push_back(quantize_element(i_in, scale_shadow));
                void'(element_q.pop_front());
                sent_count++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    i_in_valid <= 1'b0;
                end else if (element_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in       <= element_q[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off in the third scale phase
    // so the pipeline fills and backs up onto the input.
    int  stall_left;
    bit  long_hold_done;
    always @(posedge i_clk) begin
        if (phase_num == 3 && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fp8_expect_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                error_count++;
            end else begin
                sfq_pkg::t_out_item want;
                want = fp8_expect_q.pop_front();
                if (o_out.fp8_code !== want.fp8_code) begin
                    $display("%0t: fp8_code expected %h actual %h", $time,
                             want.fp8_code, o_out.fp8_code);
                    error_count++;
                end
                if (o_out.last_out !== want.last_out) begin
                    $display("%0t: last_out expected %b actual %b", $time,
                             want.last_out, o_out.last_out);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("scaled_fp8_e4m3_quantizer verification failed");
            $finish;
        end
    end

    logic [31:0] scale_list[$];

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        scale_shadow = sfq_pkg::SCALE_RESET;
        phase_num    = 0;
        quiet        = 1'b0;
        error_count  = 0;
        sent_count   = 0;
        checked_count = 0;
        idle_cycles  = 0;
        send_gap     = 0;
        stall_left   = 0;
        long_hold_done = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed elements under the reset scale of 1.0: signed zeros, infinities,
        // NaN, the saturation edge, subnormal FP8 steps and ties, far-tiny values.
        queue_element(32'h0000_0000, 1'b0);
        queue_element(32'h8000_0000, 1'b0);
        queue_element(32'h7F80_0000, 1'b0);
        queue_element(32'hFF80_0000, 1'b0);
        queue_element(32'h7FC0_0000, 1'b0);
        queue_element(32'hFFFF_FFFF, 1'b1);
        queue_element(32'h43E0_0000, 1'b0);
        queue_element(32'hC3E0_0000, 1'b0);
        queue_element(32'h43E7_FFFF, 1'b0);
        queue_element(32'h43D0_0000, 1'b0);
        queue_element(32'h43D8_0000, 1'b0);
        queue_element(32'h7F7F_FFFF, 1'b0);
        queue_element(32'h3B00_0000, 1'b0);
        queue_element(32'h3A80_0000, 1'b0);
        queue_element(32'h3A80_0001, 1'b0);
        queue_element(32'h3B40_0000, 1'b0);
        queue_element(32'hBBA0_0000, 1'b0);
        queue_element(32'h3C88_0000, 1'b0);
        queue_element(32'h3C98_0000, 1'b0);
        queue_element(32'h0000_0001, 1'b0);
        queue_element(32'h807F_FFFF, 1'b0);
        queue_element(32'h3F80_0000, 1'b0);
        queue_element(32'hBF90_0000, 1'b1);
        wait_drained();

        // Scale settings: small and large, zero, infinity, NaN, the smallest subnormal,
        // the largest finite, a negative one, random ones, and back to 1.0.
        scale_list = '{32'h3D80_0000, 32'h0000_0000, 32'h7F7F_FFFF, 32'h7F80_0000,
                       32'h7FC0_0001, 32'h0000_0001, 32'hBF00_0000, $urandom,
                       $urandom & 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000};
        foreach (scale_list[p]) begin
            write_scale(scale_list[p]);
            phase_num = p + 1;
            if (p == scale_list.size() - 1) begin
                quiet = 1'b1;
            end
            if (p == 1) begin
                queue_element(32'h0000_0000, 1'b0);
                queue_element(32'h8000_0000, 1'b0);
                queue_element(32'h3F80_0000, 1'b0);
            end
            queue_random(RAND_PER_SCALE);
            wait_drained();
        end

        $display("Sent %0d elements over %0d scale settings; %0d results checked.",
                 sent_count, scale_list.size() + 1, checked_count);
        $display("Covered IEEE specials, saturation, FP8 subnormals and backpressure.");
        if (error_count == 0 && fp8_expect_q.size() == 0) begin
            $display("scaled_fp8_e4m3_quantizer verification clean");
        end else begin
            $display("scaled_fp8_e4m3_quantizer verification failed");
        end
        $finish;
    end

endmodule
